// ===== hw/rtl/lom_pkg.sv =====
package lom_pkg;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Commands from the controller to the datapath, any mix in one cycle
    typedef struct packed {
        logic clr;        // write one zero level word during the clearing pass
        logic load;       // capture the incoming order and whether it crosses
        logic dec_init;   // point at the opposite boundary
        logic lvl_rd;     // read the level word at the current level
        logic lvl_lat;    // copy the read level word into head and fill
        logic lvl_wr;     // write head and fill back to the current level
        logic ent_rd;     // read the shares of the oldest entry
        logic consume;    // match the oldest entry against the remainder
        logic step;       // move to the next level in the walk direction
        logic scan_init;  // restart the walk at the old boundary
        logic scan_set;   // move the boundary to the current level
        logic rest_init;  // point at the order price
        logic rest;       // append the remainder to the level queue
        logic full;       // mark the remainder as dropped
        logic out_load;   // load the result register
    } lom_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_done;
        logic range_bad;
        logic crossed;
        logic left_zero;
        logic fill_zero;
        logic fill_full;
        logic at_price;
        logic at_limit;
        logic lvl_busy;
        logic out_free;
    } lom_stat_t;

endpackage

// ===== hw/rtl/lom_ctrl.sv =====
module lom_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lom_pkg::lom_stat_t st,
    output lom_pkg::lom_cmd_t  cmd
);
    import lom_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE,
        S_M_CHK, S_M_LAT, S_M_EVAL, S_M_ENT,
        S_S_INIT, S_S_RD, S_S_LAT,
        S_R_CHK, S_R_RD, S_R_LAT, S_R_DO,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (st.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (st.range_bad) begin
                    state_next = S_OUT;
                end else begin
                    cmd.dec_init = 1'b1;
                    state_next   = st.crossed ? S_M_CHK : S_R_CHK;
                end
            end
            S_M_CHK: begin
                if (st.left_zero) begin
                    state_next = S_S_INIT;
                end else begin
                    cmd.lvl_rd = 1'b1;
                    state_next = S_M_LAT;
                end
            end
            S_M_LAT: begin
                cmd.lvl_lat = 1'b1;
                state_next  = S_M_EVAL;
            end
            S_M_EVAL: begin
                if (!st.fill_zero && !st.left_zero) begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_M_ENT;
                end else begin
                    cmd.lvl_wr = 1'b1;
                    if (st.at_price || st.left_zero) begin
                        state_next = S_S_INIT;
                    end else begin
                        cmd.step   = 1'b1;
                        state_next = S_M_CHK;
                    end
                end
            end
            S_M_ENT: begin
                cmd.consume = 1'b1;
                state_next  = S_M_EVAL;
            end
            S_S_INIT: begin
                cmd.scan_init = 1'b1;
                state_next    = S_S_RD;
            end
            S_S_RD: begin
                cmd.lvl_rd = 1'b1;
                state_next = S_S_LAT;
            end
            S_S_LAT: begin
                if (st.lvl_busy || st.at_limit) begin
                    cmd.scan_set = 1'b1;
                    state_next   = S_R_CHK;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_S_RD;
                end
            end
            S_R_CHK: begin
                if (st.crossed && st.left_zero) begin
                    state_next = S_OUT;
                end else begin
                    cmd.rest_init = 1'b1;
                    state_next    = S_R_RD;
                end
            end
            S_R_RD: begin
                cmd.lvl_rd = 1'b1;
                state_next = S_R_LAT;
            end
            S_R_LAT: begin
                cmd.lvl_lat = 1'b1;
                state_next  = S_R_DO;
            end
            S_R_DO: begin
                if (st.fill_full) cmd.full = 1'b1;
                else              cmd.rest = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and the ready flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = ready_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> state_reg == S_IDLE)
        else $error("ready outside idle");

    a_out_then_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> ready_reg)
        else $error("no ready after result load");

endmodule

// ===== hw/rtl/lom_dpath.sv =====
module lom_dpath #(
    parameter int MIN_PRICE   = 0,
    parameter int MAX_PRICE   = 1023,
    parameter int LEVEL_DEPTH = 16,
    parameter int TRADER_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lom_pkg::lom_cmd_t  cmd,
    output lom_pkg::lom_stat_t st,
    input  logic               in_side,
    input  logic [15:0]        in_user_id,
    input  logic [15:0]        in_price,
    input  logic [31:0]        in_amount,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic [31:0]        out_filled_amount,
    output logic [31:0]        out_rested_amount,
    output logic [9:0]         out_best_bid_level,
    output logic [9:0]         out_best_ask_level,
    output logic [14:0]        out_resting_total
);
    import lom_pkg::*;

    localparam int NLEVELS = MAX_PRICE - MIN_PRICE + 1;
    localparam int NSLOTS  = NLEVELS * LEVEL_DEPTH;
    localparam int LW = (NLEVELS > 1) ? $clog2(NLEVELS) : 1;
    localparam int SW = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int HW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int FW = $clog2(LEVEL_DEPTH + 1);
    localparam int CW = $clog2(NSLOTS + 1);
    localparam logic [15:0] PMIN = 16'(MIN_PRICE);
    localparam logic [15:0] PMAX = 16'(MAX_PRICE);

    // Book storage
    logic [HW+FW-1:0]      lvl_mem [NLEVELS];
    logic [31:0]           shares_mem [NSLOTS];
    logic [TRADER_BITS-1:0] trader_mem [NSLOTS];

    logic [HW+FW-1:0] lvl_rdata_reg;
    logic [31:0]      shares_rdata_reg;

    logic [LW-1:0]    clr_idx_reg;
    logic             side_reg, crossed_reg;
    logic [TRADER_BITS-1:0] trader_reg;
    logic [15:0]      price_reg, idx_reg;
    logic [31:0]      amount_reg, left_reg, rested_reg;
    logic [HW-1:0]    head_reg;
    logic [FW-1:0]    fill_reg;
    logic [15:0]      ask_reg, bid_reg;
    logic [CW-1:0]    count_reg;
    logic [1:0]       stat_reg;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [31:0]      out_filled_reg, out_rested_reg;
    logic [9:0]       out_bid_reg, out_ask_reg;
    logic [14:0]      out_count_reg;

    logic [LW-1:0]    lv;
    logic [FW:0]      tail_sum;
    logic [HW-1:0]    tail_pos, head_inc;
    logic [SW-1:0]    slot_head, slot_tail;
    logic [HW-1:0]    rd_head;
    logic [FW-1:0]    rd_fill;

    // Address arithmetic
    always_comb begin
        lv        = LW'(idx_reg - PMIN);
        tail_sum  = (FW+1)'(head_reg) + (FW+1)'(fill_reg);
        if (tail_sum >= (FW+1)'(LEVEL_DEPTH))
            tail_pos = HW'(tail_sum - (FW+1)'(LEVEL_DEPTH));
        else
            tail_pos = HW'(tail_sum);
        head_inc  = (head_reg == HW'(LEVEL_DEPTH - 1)) ? '0 : HW'(head_reg + 1'b1);
        slot_head = SW'(SW'(lv) * SW'(LEVEL_DEPTH) + SW'(head_reg));
        slot_tail = SW'(SW'(lv) * SW'(LEVEL_DEPTH) + SW'(tail_pos));
        rd_head   = lvl_rdata_reg[HW+FW-1:FW];
        rd_fill   = lvl_rdata_reg[FW-1:0];
    end

    // Status to the controller
    always_comb begin
        st.clr_done  = (clr_idx_reg == LW'(NLEVELS - 1));
        st.range_bad = (price_reg > PMAX) || (price_reg < PMIN);
        st.crossed   = crossed_reg;
        st.left_zero = (left_reg == '0);
        st.fill_zero = (fill_reg == '0);
        st.fill_full = (fill_reg >= FW'(LEVEL_DEPTH));
        st.at_price  = (idx_reg == price_reg);
        st.at_limit  = side_reg ? (idx_reg == PMIN) : (idx_reg == PMAX);
        st.lvl_busy  = (rd_fill != '0);
        st.out_free  = !out_valid_reg || out_ready;
    end

    // Level memory: clear, write back, append, read
    always_ff @(posedge aclk) begin
        if (cmd.clr)
            lvl_mem[clr_idx_reg] <= '0;
        else if (cmd.lvl_wr)
            lvl_mem[lv] <= {head_reg, fill_reg};
        else if (cmd.rest)
            lvl_mem[lv] <= {head_reg, FW'(fill_reg + 1'b1)};
        if (cmd.lvl_rd)
            lvl_rdata_reg <= lvl_mem[lv];
    end

    // Entry memories: partial fill, append, read oldest
    always_ff @(posedge aclk) begin
        if (cmd.consume && (left_reg < shares_rdata_reg))
            shares_mem[slot_head] <= shares_rdata_reg - left_reg;
        else if (cmd.rest)
            shares_mem[slot_tail] <= left_reg;
        if (cmd.rest)
            trader_mem[slot_tail] <= trader_reg;
        if (cmd.ent_rd)
            shares_rdata_reg <= shares_mem[slot_head];
    end

    // Order and book registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            ask_reg     <= PMAX;
            bid_reg     <= PMIN;
            count_reg   <= '0;
            crossed_reg <= 1'b0;
        end else begin
            if (cmd.clr && !st.clr_done)
                clr_idx_reg <= LW'(clr_idx_reg + 1'b1);
            // Capture the order; the boundaries are settled while idle
            if (cmd.load) begin
                side_reg    <= in_side;
                trader_reg  <= TRADER_BITS'(in_user_id);
                price_reg   <= in_price;
                amount_reg  <= in_amount;
                left_reg    <= in_amount;
                rested_reg  <= '0;
                stat_reg    <= STAT_OK;
                crossed_reg <= in_side ? (in_price <= bid_reg) : (in_price >= ask_reg);
            end
            if (cmd.dec_init)
                idx_reg <= side_reg ? bid_reg : ask_reg;
            if (cmd.scan_init)
                idx_reg <= side_reg ? bid_reg : ask_reg;
            if (cmd.rest_init)
                idx_reg <= price_reg;
            if (cmd.step)
                idx_reg <= side_reg ? 16'(idx_reg - 1'b1) : 16'(idx_reg + 1'b1);
            if (cmd.lvl_lat) begin
                head_reg <= rd_head;
                fill_reg <= rd_fill;
            end
            // Consume the oldest entry whole, or trim it
            if (cmd.consume) begin
                if (left_reg >= shares_rdata_reg) begin
                    left_reg  <= left_reg - shares_rdata_reg;
                    head_reg  <= head_inc;
                    fill_reg  <= FW'(fill_reg - 1'b1);
                    count_reg <= CW'(count_reg - 1'b1);
                end else begin
                    left_reg <= '0;
                end
            end
            if (cmd.scan_set) begin
                if (side_reg) bid_reg <= idx_reg;
                else          ask_reg <= idx_reg;
            end
            if (cmd.full)
                stat_reg <= STAT_FULL;
            // Rest the remainder and move the boundary on this side
            if (cmd.rest) begin
                count_reg  <= CW'(count_reg + 1'b1);
                rested_reg <= left_reg;
                if (!side_reg) begin
                    if (crossed_reg || (bid_reg < price_reg)) bid_reg <= price_reg;
                end else begin
                    if (crossed_reg || (price_reg < ask_reg)) ask_reg <= price_reg;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= st.range_bad ? STAT_RANGE : stat_reg;
            out_filled_reg <= st.range_bad ? 32'd0 : amount_reg - left_reg;
            out_rested_reg <= rested_reg;
            out_bid_reg    <= bid_reg[9:0];
            out_ask_reg    <= ask_reg[9:0];
            out_count_reg  <= 15'(count_reg);
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_filled_amount  = out_filled_reg;
    assign out_rested_amount  = out_rested_reg;
    assign out_best_bid_level = out_bid_reg;
    assign out_best_ask_level = out_ask_reg;
    assign out_resting_total  = out_count_reg;

    a_consume_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.consume |-> fill_reg != '0 && left_reg != '0)
        else $error("consume on empty level or zero remainder");

    a_rest_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rest |-> fill_reg < FW'(LEVEL_DEPTH))
        else $error("append to a full level");

    a_out_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !out_valid_reg || out_ready)
        else $error("result overwritten before transfer");

endmodule

// ===== hw/rtl/limit_order_matcher.sv =====
// Channel | Ports                     | Contents
// input   | s_tvalid s_tready         | s_tdata: user_id, price, amount; s_tuser: side
// result  | m_tvalid m_tready         | m_tdata: filled, rested, bid, ask, total; m_tuser: status
//
// One order at a time. Each order is set up, walks the opposite levels while
// matching and consumes entries, rescans the boundary, rests any remainder and
// loads the result; the level walk goes over the one level memory port. After
// reset a clearing pass writes every level word before the first order is
// taken. A result waits in the output register while the next order is taken
// and worked.
module limit_order_matcher #(
    parameter int MIN_PRICE   = 0,
    parameter int MAX_PRICE   = 1023,
    parameter int LEVEL_DEPTH = 16,
    parameter int TRADER_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // user_id[15:0], price[31:16], amount[63:32]
    input  logic         s_tuser,   // side
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // filled[31:0], rested[63:32], bid[73:64],
                                    // ask[83:74], total[98:84], zeros above
    output logic [1:0]   m_tuser    // status
);
    import lom_pkg::*;

    lom_cmd_t  cmd;
    lom_stat_t st;
    logic [31:0] filled, rested;
    logic [9:0]  bid, ask;
    logic [14:0] total;

    lom_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lom_dpath #(
        .MIN_PRICE   (MIN_PRICE),
        .MAX_PRICE   (MAX_PRICE),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .TRADER_BITS (TRADER_BITS)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .st                 (st),
        .in_side            (s_tuser),
        .in_user_id         (s_tdata[15:0]),
        .in_price           (s_tdata[31:16]),
        .in_amount          (s_tdata[63:32]),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_status         (m_tuser),
        .out_filled_amount  (filled),
        .out_rested_amount  (rested),
        .out_best_bid_level (bid),
        .out_best_ask_level (ask),
        .out_resting_total  (total)
    );

    assign m_tdata = {5'd0, total, ask, bid, rested, filled};

endmodule
